FILE: design/lzlc_pkg.sv
// ----------------------------------------------------------------------------
// lzlc_pkg: shared types and constants of the lamp zone light classifier
// Field widths, light case and kind codes, zone codes and the item structs
// that travel between the stages.
// ----------------------------------------------------------------------------
package lzlc_pkg;

    // Field widths
    localparam int DIM_W    = 11;
    localparam int COUNT_W  = 21;
    localparam int CASE_W   = 4;
    localparam int KIND_W   = 3;
    localparam int ZONE_W   = 3;
    localparam int LAMP_W   = 3;
    localparam int ZONES    = 4;
    localparam int ZIDX_W   = $clog2(ZONES);

    // Default box dimension limit
    localparam int MAX_DIM_DEFAULT = 1024;

    // Lamp count register
    localparam logic [LAMP_W-1:0] LAMP_THREE = LAMP_W'(3);
    localparam logic [LAMP_W-1:0] LAMP_RESET = LAMP_W'(4);

    // Saturation value of a zone counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // floor(w/3) as (w * RECIP3) >> RECIP3_SHIFT, exact for w below 2**DIM_W
    localparam int RECIP3       = 683;
    localparam int RECIP3_W     = 10;
    localparam int RECIP3_SHIFT = DIM_W;

    // Light case codes
    localparam logic [CASE_W-1:0] CASE_NONE        = CASE_W'(0);
    localparam logic [CASE_W-1:0] CASE3_RED        = CASE_W'(1);
    localparam logic [CASE_W-1:0] CASE3_YELLOW     = CASE_W'(2);
    localparam logic [CASE_W-1:0] CASE3_GREEN      = CASE_W'(3);
    localparam logic [CASE_W-1:0] CASE4_RED        = CASE_W'(4);
    localparam logic [CASE_W-1:0] CASE4_YELLOW     = CASE_W'(5);
    localparam logic [CASE_W-1:0] CASE4_GREEN      = CASE_W'(6);
    localparam logic [CASE_W-1:0] CASE4_LEFT_RED   = CASE_W'(7);
    localparam logic [CASE_W-1:0] CASE4_LEFT_GREEN = CASE_W'(8);

    // Light kind codes
    localparam logic [KIND_W-1:0] KIND_NONE          = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_RED           = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_YELLOW        = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_STRAIGHT      = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_LEFT          = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_STRAIGHT_LEFT = KIND_W'(5);

    // Winning zone codes, the last two are the left-arrow remaps
    localparam logic [ZONE_W-1:0] ZONE_0          = ZONE_W'(0);
    localparam logic [ZONE_W-1:0] ZONE_1          = ZONE_W'(1);
    localparam logic [ZONE_W-1:0] ZONE_2          = ZONE_W'(2);
    localparam logic [ZONE_W-1:0] ZONE_3          = ZONE_W'(3);
    localparam logic [ZONE_W-1:0] ZONE_LEFT_RED   = ZONE_W'(4);
    localparam logic [ZONE_W-1:0] ZONE_LEFT_GREEN = ZONE_W'(5);

    // Pixel request
    typedef struct packed {
        logic             lit;
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
        logic             last_pixel;
    } pixel_t;

    // Result request
    typedef struct packed {
        logic [CASE_W-1:0]  light_case;
        logic [KIND_W-1:0]  light_kind;
        logic [ZONE_W-1:0]  winning_zone;
        logic [COUNT_W-1:0] zone0_lit;
        logic [COUNT_W-1:0] zone1_lit;
        logic [COUNT_W-1:0] zone2_lit;
        logic [COUNT_W-1:0] zone3_lit;
    } result_t;

    // Zone counts of a finished box, handed to the decision stage
    typedef struct packed {
        logic [ZONES-1:0][COUNT_W-1:0] counts;
        logic [DIM_W-1:0]              box_width;
        logic [DIM_W-1:0]              box_height;
        logic                          three;
    } zone_snap_t;

endpackage

FILE: design/lzlc_zone_counter.sv
// ----------------------------------------------------------------------------
// lzlc_zone_counter: pixel register, column tracking and zone counters
// Registers each pixel, finds its vertical zone from the column position
// and, if the pixel is lit, bumps that zone's saturating counter. On the last pixel of a box the
// counts are captured into the snapshot register and the counters clear.
// ----------------------------------------------------------------------------
module lzlc_zone_counter
    import lzlc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       three,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  pixel_t     pixel,
    output logic       snap_valid,
    input  logic       snap_ready,
    output zone_snap_t snap
);

    localparam int COL_W = $clog2(MAX_DIM);
    localparam int Q_W   = DIM_W - 1;
    localparam int CMP_W = ((COL_W > DIM_W + 1) ? COL_W : DIM_W + 1) + 1;
    localparam logic [DIM_W-1:0] DIM_CLAMP =
        (MAX_DIM >= (2 ** DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

    logic                          s1_valid_reg;
    pixel_t                        s1_item_reg;
    logic [COL_W-1:0]              col_reg;
    logic [COL_W-1:0]              col_next;
    logic [ZONES-1:0][COUNT_W-1:0] count_reg;
    logic [ZONES-1:0][COUNT_W-1:0] count_next;
    logic                          snap_valid_reg;
    zone_snap_t                    snap_reg;

    logic                          snap_free;
    logic                          s1_fire;
    pixel_t                        pixel_clamped;
    logic [DIM_W+RECIP3_W-1:0]     q3_prod;
    logic [Q_W-1:0]                q;
    logic [CMP_W-1:0]              bound1;
    logic [CMP_W-1:0]              bound2;
    logic [CMP_W-1:0]              bound3;
    logic [CMP_W-1:0]              col_ext;
    logic [CMP_W-1:0]              col_plus;
    logic [CMP_W-1:0]              width_ext;
    logic [ZIDX_W-1:0]             zone;

    // Handshake through the pixel and snapshot registers
    assign snap_free   = !snap_valid_reg || snap_ready;
    assign s1_fire     = s1_valid_reg && (!s1_item_reg.last_pixel || snap_free);
    assign pixel_ready = !s1_valid_reg || s1_fire;

    // Oversized dimensions are taken as the limit
    always_comb
    begin
        pixel_clamped = pixel;
        if (pixel.box_width > DIM_CLAMP)
        begin
            pixel_clamped.box_width = DIM_CLAMP;
        end
        if (pixel.box_height > DIM_CLAMP)
        begin
            pixel_clamped.box_height = DIM_CLAMP;
        end
    end

    // Zone boundaries q, 2q, 3q with q = floor(w / lamps)
    always_comb
    begin
        q3_prod = (DIM_W + RECIP3_W)'(s1_item_reg.box_width) *
                  (DIM_W + RECIP3_W)'(RECIP3);
        if (three)
        begin
            q = q3_prod[RECIP3_SHIFT +: Q_W];
        end
        else
        begin
            q = Q_W'(s1_item_reg.box_width[DIM_W-1:2]);
        end
        bound1 = CMP_W'(q);
        bound2 = CMP_W'(q) << 1;
        bound3 = bound2 + bound1;
    end

    // Zone of the current column
    always_comb
    begin
        col_ext = CMP_W'(col_reg);
        if (col_ext < bound1)
        begin
            zone = ZIDX_W'(0);
        end
        else if (col_ext < bound2)
        begin
            zone = ZIDX_W'(1);
        end
        else if (three || (col_ext < bound3))
        begin
            zone = ZIDX_W'(2);
        end
        else
        begin
            zone = ZIDX_W'(3);
        end
    end

    // Saturating counter update, one lane per zone
    always_comb
    begin
        for (int k = 0; k < ZONES; k++)
        begin
            count_next[k] = count_reg[k];
            if (s1_item_reg.lit && (zone == ZIDX_W'(k)) && (count_reg[k] != COUNT_MAX))
            begin
                count_next[k] = count_reg[k] + COUNT_W'(1);
            end
        end
    end

    // Column advance, wrapping at the box width
    always_comb
    begin
        col_plus  = col_ext + CMP_W'(1);
        width_ext = CMP_W'(s1_item_reg.box_width);
        if (col_plus >= width_ext)
        begin
            col_next = '0;
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
        end
    end

    // Pixel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            s1_item_reg <= pixel_clamped;
        end
    end

    // Counters and column position, cleared after each box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            col_reg   <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_item_reg.last_pixel)
            begin
                count_reg <= '0;
                col_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                col_reg   <= col_next;
            end
        end
    end

    // Snapshot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_item_reg.last_pixel)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_item_reg.last_pixel)
        begin
            snap_reg.counts     <= count_next;
            snap_reg.box_width  <= s1_item_reg.box_width;
            snap_reg.box_height <= s1_item_reg.box_height;
            snap_reg.three      <= three;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

FILE: design/lzlc_decide.sv
// ----------------------------------------------------------------------------
// lzlc_decide: winner selection, left-arrow remap and result register
// Picks the zone with the most lit pixels, applies the zone 2 threshold
// test against the box area and maps the winner to light case and kind.
// ----------------------------------------------------------------------------
module lzlc_decide
    import lzlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       snap_valid,
    output logic       snap_ready,
    input  zone_snap_t snap,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    localparam int AREA_W = 2 * DIM_W;
    localparam int THR_W  = COUNT_W + 5;

    logic                          result_valid_reg;
    result_t                       result_reg;
    result_t                       result_next;

    logic [ZONES-1:0][COUNT_W-1:0] c;
    logic [COUNT_W-1:0]            best;
    logic [ZIDX_W-1:0]             best_idx;
    logic [AREA_W-1:0]             area;
    logic [THR_W-1:0]              c2_scaled;
    logic                          zone2_strong;
    logic [ZONE_W-1:0]             win;

    // Zone 3 is ignored for three lamps
    always_comb
    begin
        c = snap.counts;
        if (snap.three)
        begin
            c[3] = '0;
        end
    end

    // Largest count, ties go to the lowest zone
    always_comb
    begin
        best     = c[0];
        best_idx = '0;
        for (int k = 1; k < ZONES; k++)
        begin
            if (c[k] > best)
            begin
                best     = c[k];
                best_idx = ZIDX_W'(k);
            end
        end
    end

    // zone2 > floor(area / d) is the same as zone2 * d > area
    always_comb
    begin
        area = AREA_W'(snap.box_width) * AREA_W'(snap.box_height);
        if (snap.three)
        begin
            c2_scaled = (THR_W'(c[2]) << 3) + (THR_W'(c[2]) << 2);
        end
        else
        begin
            c2_scaled = (THR_W'(c[2]) << 5) - (THR_W'(c[2]) << 2);
        end
        zone2_strong = c2_scaled > THR_W'(area);
    end

    // Zone 2 remap: left-arrow codes for four lamps, zone 0 to zone 2 for three lamps
    always_comb
    begin
        win = ZONE_W'(best_idx);
        if (zone2_strong)
        begin
            if (snap.three)
            begin
                if (win == ZONE_0)
                begin
                    win = ZONE_2;
                end
            end
            else
            begin
                if (win == ZONE_0)
                begin
                    win = ZONE_LEFT_RED;
                end
                else if (win == ZONE_3)
                begin
                    win = ZONE_LEFT_GREEN;
                end
            end
        end
    end

    // Winner to light case and kind
    always_comb
    begin
        result_next.winning_zone = win;
        result_next.zone0_lit    = c[0];
        result_next.zone1_lit    = c[1];
        result_next.zone2_lit    = c[2];
        result_next.zone3_lit    = c[3];
        if (snap.three)
        begin
            unique case (win)
                ZONE_0:
                begin
                    result_next.light_case = CASE3_RED;
                    result_next.light_kind = KIND_RED;
                end
                ZONE_1:
                begin
                    result_next.light_case = CASE3_YELLOW;
                    result_next.light_kind = KIND_YELLOW;
                end
                ZONE_2:
                begin
                    result_next.light_case = CASE3_GREEN;
                    result_next.light_kind = KIND_STRAIGHT;
                end
                default:
                begin
                    result_next.light_case = CASE_NONE;
                    result_next.light_kind = KIND_NONE;
                end
            endcase
        end
        else
        begin
            unique case (win)
                ZONE_0:
                begin
                    result_next.light_case = CASE4_RED;
                    result_next.light_kind = KIND_RED;
                end
                ZONE_1:
                begin
                    result_next.light_case = CASE4_YELLOW;
                    result_next.light_kind = KIND_YELLOW;
                end
                ZONE_3:
                begin
                    result_next.light_case = CASE4_GREEN;
                    result_next.light_kind = KIND_STRAIGHT;
                end
                ZONE_LEFT_RED:
                begin
                    result_next.light_case = CASE4_LEFT_RED;
                    result_next.light_kind = KIND_LEFT;
                end
                ZONE_LEFT_GREEN:
                begin
                    result_next.light_case = CASE4_LEFT_GREEN;
                    result_next.light_kind = KIND_STRAIGHT_LEFT;
                end
                default:
                begin
                    result_next.light_case = CASE_NONE;
                    result_next.light_kind = KIND_NONE;
                end
            endcase
        end
    end

    // Result register
    assign snap_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            result_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: design/lamp_zone_light_classifier.sv
// ----------------------------------------------------------------------------
// lamp_zone_light_classifier: traffic light classifier from zone lit counts
// Counts lit pixels per vertical lamp zone of a box and, on the last pixel,
// reports the light case, light kind, winning zone and the zone counts.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle, unless a box's last pixel waits for the snapshot register.
// Path: the last pixel passes through the pixel register, the snapshot register
// and the result register in turn before the result is valid.
// Reset: zone counters and column position clear, lamp_count returns to 4,
// no request is pending on either side.
module lamp_zone_light_classifier
    import lzlc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LAMP_W-1:0] cfg_data,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  pixel_t            pixel,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    logic [LAMP_W-1:0] lamp_count_reg;
    logic              three;
    logic              snap_valid;
    logic              snap_ready;
    zone_snap_t        snap;

    // Lamp count register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_count_reg <= LAMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lamp_count_reg <= cfg_data;
        end
    end

    // Any count other than three runs as four lamps
    assign three = (lamp_count_reg == LAMP_THREE);

    lzlc_zone_counter #(
        .MAX_DIM (MAX_DIM)
    ) u_zone_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .three       (three),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap)
    );

    lzlc_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
